// ----- hdl/sshu_pkg.sv -----
// shared types, constants and register indexes for the sweep scanner with detect hold
// no dependencies; imported by every module of the block
package sshu_pkg;

  localparam int ANGLE_W      = 8;
  localparam int ECHO_W       = 16;
  localparam int CONFIRM_W    = 8;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 16;
  localparam int RUN_COUNT_BITS_DEF = 8;

  // item kinds carried in tuser
  localparam logic OP_MEAS = 1'b0;
  localparam logic OP_STEP = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_NEAR_LIMIT     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NEAR_CONFIRM   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CLEAR_CONFIRM  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_LO       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_HI       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_DEG       = 3'd5;

  // reset values
  localparam logic [ECHO_W-1:0]    NEAR_LIMIT_RST     = 16'd583;
  localparam logic [CONFIRM_W-1:0] NEAR_CONFIRM_RST   = 8'd3;
  localparam logic [CONFIRM_W-1:0] CLEAR_CONFIRM_RST  = 8'd5;
  localparam logic [ANGLE_W-1:0]   ANGLE_LO_RST       = 8'd15;
  localparam logic [ANGLE_W-1:0]   ANGLE_HI_RST       = 8'd165;
  localparam logic [ANGLE_W-1:0]   STEP_DEG_RST       = 8'd4;

  typedef struct packed {
    logic [ECHO_W-1:0]    near_limit_us;
    logic [CONFIRM_W-1:0] near_confirm;
    logic [CONFIRM_W-1:0] clear_confirm;
    logic [ANGLE_W-1:0]   angle_lo;
    logic [ANGLE_W-1:0]   angle_hi;
    logic [ANGLE_W-1:0]   step_deg;
  } cfg_t;

  typedef struct packed {
    logic hold;       // hold state before the current item
    logic hold_next;  // hold state after the current item
    logic near;       // current item counted as near
    logic near_any;   // near run counter nonzero
    logic miss_any;   // miss run counter nonzero
  } det_stat_t;

endpackage

// ----- hdl/sweep_scanner_with_detect_hold_unit.sv -----
// top level of the pan sweep scanner with confirmed-detection hold
// depends on sshu_pkg, sshu_cfg_regs, sshu_detect and sshu_sweep

// Each transaction on the slave stream is either an echo measurement
// (tuser = 0, tdata = echo duration in us, 0 = timeout) or a step tick
// (tuser = 1), and each gives exactly one result transaction carrying the
// pan angle after it, the hold flag and whether the echo counted as near.
// The block takes one transaction every cycle unless a stalled result holds it
// off. The accepting edge loads the input register, and the result register is
// loaded from it once the result side is free; the run counters, hold flag and
// angle are updated combinationally between those two registers. A stalled
// result only holds off the input once the input register is full too.
// Configuration writes are taken at any time with cfg_ready always high but
// must only be made while no transaction is in flight; after reset the angle
// starts at 15.
module sweep_scanner_with_detect_hold_unit import sshu_pkg::*; #(
  parameter int RUN_COUNT_BITS = RUN_COUNT_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [ECHO_W-1:0]     s_axis_tdata,  // [15:0] echo_us
  input  logic                  s_axis_tuser,  // [0] op
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [15:0]           m_axis_tdata,  // [7:0] angle, [8] holding, [9] near, rest zero
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t               cfg;
  det_stat_t          det_stat;
  logic [ANGLE_W-1:0] angle, angle_next;

  logic               s1_valid;
  logic               s1_op;
  logic [ECHO_W-1:0]  s1_echo;

  logic               out_valid;
  logic [ANGLE_W-1:0] out_angle;
  logic               out_hold;
  logic               out_near;

  logic               advance;
  logic               en;

  assign advance       = !out_valid || m_axis_tready;
  assign en            = s1_valid && advance;
  assign s_axis_tready = !s1_valid || advance;

  sshu_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_addr  (cfg_addr),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  sshu_detect #(
    .RUN_COUNT_BITS (RUN_COUNT_BITS)
  ) u_detect (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .op      (s1_op),
    .echo_us (s1_echo),
    .cfg     (cfg),
    .stat    (det_stat)
  );

  sshu_sweep u_sweep (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .op         (s1_op),
    .hold       (det_stat.hold),
    .cfg        (cfg),
    .angle      (angle),
    .angle_next (angle_next)
  );

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_axis_tready) begin
      s1_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      s1_op   <= s_axis_tuser;
      s1_echo <= s_axis_tdata;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_angle <= angle_next;
      out_hold  <= det_stat.hold_next;
      out_near  <= det_stat.near;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {6'b0, out_near, out_hold, out_angle};

  // a step tick never reports a near echo
  a_step_not_near: assert property (@(posedge clk) disable iff (rst)
    (en && (s1_op == OP_STEP)) |=> !out_near)
    else $error("step tick reported as near");

  // a step tick leaves the hold state alone
  a_step_keeps_hold: assert property (@(posedge clk) disable iff (rst)
    (en && (s1_op == OP_STEP)) |=> (det_stat.hold == $past(det_stat.hold)))
    else $error("hold changed on a step tick");

  // the angle is frozen while holding
  a_hold_freezes_angle: assert property (@(posedge clk) disable iff (rst)
    (en && det_stat.hold) |=> (angle == $past(angle)))
    else $error("angle moved while holding");

  // near and miss runs are never both in progress
  a_runs_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(det_stat.near_any && det_stat.miss_any))
    else $error("near and miss runs both nonzero");

endmodule

// ----- hdl/sshu_cfg_regs.sv -----
// configuration register file for the sweep scanner
// depends on sshu_pkg for register indexes, reset values and cfg_t
module sshu_cfg_regs import sshu_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                  cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.near_limit_us  <= NEAR_LIMIT_RST;
      cfg.near_confirm   <= NEAR_CONFIRM_RST;
      cfg.clear_confirm  <= CLEAR_CONFIRM_RST;
      cfg.angle_lo       <= ANGLE_LO_RST;
      cfg.angle_hi       <= ANGLE_HI_RST;
      cfg.step_deg       <= STEP_DEG_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_addr)
        REG_NEAR_LIMIT:     cfg.near_limit_us  <= cfg_data[ECHO_W-1:0];
        REG_NEAR_CONFIRM:   cfg.near_confirm   <= cfg_data[CONFIRM_W-1:0];
        REG_CLEAR_CONFIRM:  cfg.clear_confirm  <= cfg_data[CONFIRM_W-1:0];
        REG_ANGLE_LO:       cfg.angle_lo       <= cfg_data[ANGLE_W-1:0];
        REG_ANGLE_HI:       cfg.angle_hi       <= cfg_data[ANGLE_W-1:0];
        REG_STEP_DEG:       cfg.step_deg       <= cfg_data[ANGLE_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ----- hdl/sshu_detect.sv -----
// near detection, saturating run counters and the hold flag
// depends on sshu_pkg for cfg_t, det_stat_t and item kinds
module sshu_detect import sshu_pkg::*; #(
  parameter int RUN_COUNT_BITS = RUN_COUNT_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              op,
  input  logic [ECHO_W-1:0] echo_us,
  input  cfg_t              cfg,
  output det_stat_t         stat
);

  localparam int CMP_W = (RUN_COUNT_BITS > CONFIRM_W) ? RUN_COUNT_BITS : CONFIRM_W;

  logic [RUN_COUNT_BITS-1:0] near_run, near_run_next;
  logic [RUN_COUNT_BITS-1:0] miss_run, miss_run_next;
  logic                      hold_flag, hold_flag_next;
  logic                      is_near;
  logic                      hold_mid;
  logic [RUN_COUNT_BITS-1:0] near_inc, miss_inc;

  assign is_near  = (op == OP_MEAS) && (echo_us != '0) && (echo_us <= cfg.near_limit_us);
  // saturating increments
  assign near_inc = (near_run == '1) ? near_run : near_run + 1'b1;
  assign miss_inc = (miss_run == '1) ? miss_run : miss_run + 1'b1;

  always_comb begin
    near_run_next  = near_run;
    miss_run_next  = miss_run;
    hold_flag_next = hold_flag;
    hold_mid       = hold_flag;
    if (op == OP_MEAS) begin
      if (is_near) begin
        near_run_next = near_inc;
        miss_run_next = '0;
      end else begin
        near_run_next = '0;
        miss_run_next = hold_flag ? miss_inc : '0;
      end
      hold_mid = hold_flag ||
                 (CMP_W'(near_run_next) >= CMP_W'(cfg.near_confirm));
      hold_flag_next = hold_mid;
      // leaving hold can happen in the same transaction that entered it
      if (hold_mid && (CMP_W'(miss_run_next) >= CMP_W'(cfg.clear_confirm))) begin
        hold_flag_next = 1'b0;
        near_run_next  = '0;
        miss_run_next  = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      near_run  <= '0;
      miss_run  <= '0;
      hold_flag <= 1'b0;
    end else if (en) begin
      near_run  <= near_run_next;
      miss_run  <= miss_run_next;
      hold_flag <= hold_flag_next;
    end
  end

  assign stat.hold      = hold_flag;
  assign stat.hold_next = hold_flag_next;
  assign stat.near      = is_near;
  assign stat.near_any  = (near_run != '0);
  assign stat.miss_any  = (miss_run != '0);

endmodule

// ----- hdl/sshu_sweep.sv -----
// bouncing pan angle between the sweep limits, frozen while holding
// depends on sshu_pkg for cfg_t, widths and item kinds
module sshu_sweep import sshu_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               op,
  input  logic               hold,
  input  cfg_t               cfg,
  output logic [ANGLE_W-1:0] angle,
  output logic [ANGLE_W-1:0] angle_next
);

  logic               going_up, going_up_next;
  logic [ANGLE_W:0]   up_sum;
  logic [ANGLE_W:0]   down_floor;

  assign up_sum     = {1'b0, angle} + {1'b0, cfg.step_deg};
  // angle - step <= low limit  is the same as  angle <= low limit + step
  assign down_floor = {1'b0, cfg.angle_lo} + {1'b0, cfg.step_deg};

  always_comb begin
    angle_next    = angle;
    going_up_next = going_up;
    if ((op == OP_STEP) && !hold) begin
      if (going_up) begin
        if (up_sum >= {1'b0, cfg.angle_hi}) begin
          angle_next    = cfg.angle_hi;
          going_up_next = 1'b0;
        end else begin
          angle_next = up_sum[ANGLE_W-1:0];
        end
      end else begin
        if ({1'b0, angle} <= down_floor) begin
          angle_next    = cfg.angle_lo;
          going_up_next = 1'b1;
        end else begin
          angle_next = angle - cfg.step_deg;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      angle    <= ANGLE_LO_RST;
      going_up <= 1'b1;
    end else if (en) begin
      angle    <= angle_next;
      going_up <= going_up_next;
    end
  end

endmodule

// ----- bench/sweep_scanner_with_detect_hold_unit_tb.sv -----
// self-checking bench for the pan sweep scanner with confirmed-detection hold
// depends on sshu_pkg and sweep_scanner_with_detect_hold_unit; drives both streams
// and the config channel, predicts every result and compares it on the master side
module sweep_scanner_with_detect_hold_unit_tb;
  import sshu_pkg::*;

  localparam int RUN_BITS = RUN_COUNT_BITS_DEF;
  localparam logic [RUN_BITS-1:0] RUN_MAX = {RUN_BITS{1'b1}};
  localparam int RANDOM_ITEMS = 1000;
  localparam int DRAIN_CYCLES = 6;
  localparam int CYCLE_LIMIT = 500000;

  typedef struct {
    logic [ANGLE_W-1:0] angle;
    logic holding;
    logic near;
  } scan_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [ECHO_W-1:0] s_axis_tdata = '0;  // [15:0] echo_us
  logic s_axis_tuser = OP_MEAS;           // [0] op
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;              // [7:0] angle, [8] holding, [9] near
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // predictor copy of the registers and the scan state
  cfg_t scan_cfg;
  logic [ANGLE_W-1:0] pan_pos;
  logic sweep_up;
  logic hold_active;
  logic [RUN_BITS-1:0] near_count;
  logic [RUN_BITS-1:0] miss_count;

  scan_result_t scan_expect[$];
  int err_count = 0;
  int items_sent = 0;
  int cycle_count = 0;
  bit no_idle = 1'b0;

  sweep_scanner_with_detect_hold_unit u_dut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_addr(cfg_addr),
    .cfg_data(cfg_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    err_count++;
  endtask

  function automatic void reset_scan_state();
    scan_cfg.near_limit_us = NEAR_LIMIT_RST;
    scan_cfg.near_confirm = NEAR_CONFIRM_RST;
    scan_cfg.clear_confirm = CLEAR_CONFIRM_RST;
    scan_cfg.angle_lo = ANGLE_LO_RST;
    scan_cfg.angle_hi = ANGLE_HI_RST;
    scan_cfg.step_deg = STEP_DEG_RST;
    pan_pos = ANGLE_LO_RST;
    sweep_up = 1'b1;
    hold_active = 1'b0;
    near_count = '0;
    miss_count = '0;
  endfunction

  function automatic logic [RUN_BITS-1:0] bump_run(input logic [RUN_BITS-1:0] v);
    return (v == RUN_MAX) ? RUN_MAX : v + 1'b1;
  endfunction

  // one item: update run counters, hold flag and angle, return the result
  function automatic scan_result_t predict_scan(input logic op, input logic [ECHO_W-1:0] echo);
    scan_result_t r;
    int a;
    logic is_near;
    is_near = 1'b0;
    if (op == OP_MEAS) begin
      is_near = (echo != '0) && (echo <= scan_cfg.near_limit_us);
      if (is_near) begin
        near_count = bump_run(near_count);
        miss_count = '0;
      end else begin
        near_count = '0;
        miss_count = hold_active ? bump_run(miss_count) : '0;
      end
      if (!hold_active && near_count >= scan_cfg.near_confirm) hold_active = 1'b1;
      if (hold_active && miss_count >= scan_cfg.clear_confirm) begin
        hold_active = 1'b0;
        near_count = '0;
        miss_count = '0;
      end
    end else if (!hold_active) begin
      a = int'(pan_pos);
      if (sweep_up) begin
        a += int'(scan_cfg.step_deg);
        if (a >= int'(scan_cfg.angle_hi)) begin
          a = int'(scan_cfg.angle_hi);
          sweep_up = 1'b0;
        end
      end else begin
        a -= int'(scan_cfg.step_deg);
        if (a <= int'(scan_cfg.angle_lo)) begin
          a = int'(scan_cfg.angle_lo);
          sweep_up = 1'b1;
        end
      end
      pan_pos = a[ANGLE_W-1:0];
    end
    r.angle = pan_pos;
    r.holding = hold_active;
    r.near = is_near;
    return r;
  endfunction

  // tvalid stays high between back-to-back items
  task automatic send_item(input logic op, input logic [ECHO_W-1:0] echo);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= echo;
    s_axis_tuser <= op;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    scan_expect.push_back(predict_scan(op, echo));
    items_sent++;
  endtask

  task automatic settle_block();
    s_axis_tvalid <= 1'b0;
    while (scan_expect.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic apply_config(input cfg_t c);
    settle_block();
    write_reg(REG_NEAR_LIMIT, c.near_limit_us);
    write_reg(REG_NEAR_CONFIRM, CFG_DATA_W'(c.near_confirm));
    write_reg(REG_CLEAR_CONFIRM, CFG_DATA_W'(c.clear_confirm));
    write_reg(REG_ANGLE_LO, CFG_DATA_W'(c.angle_lo));
    write_reg(REG_ANGLE_HI, CFG_DATA_W'(c.angle_hi));
    write_reg(REG_STEP_DEG, CFG_DATA_W'(c.step_deg));
    cfg_valid <= 1'b0;
    scan_cfg = c;
  endtask

  function automatic cfg_t make_cfg(input int limit, input int det, input int clr,
                                    input int lo, input int hi, input int step);
    cfg_t c;
    c.near_limit_us = limit[ECHO_W-1:0];
    c.near_confirm = det[CONFIRM_W-1:0];
    c.clear_confirm = clr[CONFIRM_W-1:0];
    c.angle_lo = lo[ANGLE_W-1:0];
    c.angle_hi = hi[ANGLE_W-1:0];
    c.step_deg = step[ANGLE_W-1:0];
    return c;
  endfunction

  function automatic cfg_t pick_setting();
    int limit, det, clr, lo, hi, step, sel;
    sel = $urandom_range(0, 7);
    case (sel)
      0: limit = 0;
      1: limit = 65535;
      2: limit = $urandom_range(0, 65535);
      default: limit = $urandom_range(200, 2000);
    endcase
    sel = $urandom_range(0, 9);
    det = (sel == 0) ? 0 : (sel == 1) ? 255 : $urandom_range(1, 6);
    sel = $urandom_range(0, 9);
    clr = (sel == 0) ? 0 : (sel == 1) ? 255 : $urandom_range(1, 8);
    sel = $urandom_range(0, 7);
    case (sel)
      0: begin  // limits out of order
        lo = $urandom_range(90, 180);
        hi = $urandom_range(0, 89);
      end
      1: begin
        lo = $urandom_range(0, 180);
        hi = lo;
      end
      2: begin
        lo = 0;
        hi = 180;
      end
      default: begin
        lo = $urandom_range(0, 90);
        hi = $urandom_range(lo + 1, 180);
      end
    endcase
    sel = $urandom_range(0, 7);
    step = (sel == 0) ? 180 : (sel == 1) ? 1 : $urandom_range(1, 30);
    return make_cfg(limit, det, clr, lo, hi, step);
  endfunction

  function automatic logic [ECHO_W-1:0] near_echo();
    if (scan_cfg.near_limit_us == '0) return ECHO_W'($urandom);
    if ($urandom_range(0, 3) == 0) return scan_cfg.near_limit_us;
    return ECHO_W'($urandom_range(1, scan_cfg.near_limit_us));
  endfunction

  function automatic logic [ECHO_W-1:0] miss_echo();
    int sel;
    sel = $urandom_range(0, 3);
    if (sel == 0 || scan_cfg.near_limit_us == '1) return '0;
    if (sel == 1) return scan_cfg.near_limit_us + 1'b1;
    return ECHO_W'($urandom_range(int'(scan_cfg.near_limit_us) + 1, 65535));
  endfunction

  // result side: random stalls on tready, compare each transaction
  initial begin : result_checker
    scan_result_t want;
    int stall;
    wait (rst == 1'b0);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 6);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk);
      while (!(m_axis_tvalid && m_axis_tready)) @(posedge clk);
      if (scan_expect.size() == 0) begin
        report_mismatch($sformatf("unexpected result tdata=%h", m_axis_tdata));
      end else begin
        want = scan_expect.pop_front();
        if (m_axis_tdata[7:0] !== want.angle)
          report_mismatch($sformatf("angle got %0d want %0d", m_axis_tdata[7:0], want.angle));
        if (m_axis_tdata[8] !== want.holding)
          report_mismatch($sformatf("holding got %b want %b", m_axis_tdata[8], want.holding));
        if (m_axis_tdata[9] !== want.near)
          report_mismatch($sformatf("near got %b want %b", m_axis_tdata[9], want.near));
        if (m_axis_tdata[15:10] !== '0)
          report_mismatch($sformatf("padding bits got %b", m_axis_tdata[15:10]));
      end
    end
  end

  // reset settings: sweep, near edge at the limit, timeout, hold and release
  task automatic test_default_sweep_and_hold();
    send_item(OP_STEP, 16'hFFFF);
    send_item(OP_STEP, 16'h0000);
    send_item(OP_MEAS, 16'd583);
    send_item(OP_MEAS, 16'd584);
    send_item(OP_MEAS, 16'd0);
    send_item(OP_MEAS, 16'hFFFF);
    send_item(OP_MEAS, 16'd1);
    send_item(OP_MEAS, 16'd300);
    send_item(OP_MEAS, 16'd583);
    send_item(OP_STEP, 16'd0);
    repeat (5) send_item(OP_MEAS, 16'd584);
    send_item(OP_STEP, 16'd0);
  endtask

  task automatic test_config_extremes();
    // nothing counts as near, full-range clamping at both ends
    apply_config(make_cfg(0, 1, 1, 0, 180, 180));
    send_item(OP_MEAS, 16'd0);
    send_item(OP_MEAS, 16'd1);
    send_item(OP_MEAS, 16'hFFFF);
    send_item(OP_STEP, 16'd0);
    send_item(OP_STEP, 16'd0);
    // zero confirms: enter and leave hold in one item; limits reversed
    apply_config(make_cfg(65535, 0, 0, 180, 0, 1));
    send_item(OP_MEAS, 16'hFFFF);
    send_item(OP_MEAS, 16'd0);
    send_item(OP_STEP, 16'd0);
    send_item(OP_STEP, 16'd0);
    send_item(OP_STEP, 16'd0);
    // zero detect: any measurement holds, step frozen until two misses
    apply_config(make_cfg(1000, 0, 2, 10, 20, 7));
    send_item(OP_MEAS, 16'd0);
    send_item(OP_STEP, 16'd0);
    send_item(OP_MEAS, 16'd2000);
    send_item(OP_MEAS, 16'd0);
    send_item(OP_STEP, 16'd0);
  endtask

  // long runs push the run counters to their ceiling
  task automatic test_counter_saturation();
    apply_config(make_cfg(65535, 255, 255, 0, 180, 1));
    repeat (260) send_item(OP_MEAS, ECHO_W'($urandom_range(1, 65535)));
    repeat (3) send_item(OP_STEP, ECHO_W'($urandom));
    repeat (256) send_item(OP_MEAS, 16'd0);
    send_item(OP_STEP, ECHO_W'($urandom));
  endtask

  task automatic run_random_phase();
    int target, kind, len, i;
    apply_config(pick_setting());
    no_idle = ($urandom_range(0, 3) == 0);
    target = items_sent + $urandom_range(60, 140);
    while (items_sent < target) begin
      kind = $urandom_range(0, 9);
      if (kind <= 2) begin
        len = int'(scan_cfg.near_confirm) + $urandom_range(0, 3);
        if (len > 20) len = 20;
        for (i = 0; i < len; i++) begin
          if ($urandom_range(0, 7) == 0) send_item(OP_STEP, ECHO_W'($urandom));
          send_item(OP_MEAS, near_echo());
        end
      end else if (kind <= 4) begin
        len = int'(scan_cfg.clear_confirm) + $urandom_range(0, 3);
        if (len > 20) len = 20;
        for (i = 0; i < len; i++) begin
          if ($urandom_range(0, 7) == 0) send_item(OP_STEP, ECHO_W'($urandom));
          send_item(OP_MEAS, miss_echo());
        end
      end else if (kind <= 6) begin
        len = $urandom_range(1, 10);
        for (i = 0; i < len; i++) send_item(OP_STEP, ECHO_W'($urandom));
      end else if (kind == 7) begin
        // broken runs: near and miss interleaved
        len = $urandom_range(1, 8);
        for (i = 0; i < len; i++) send_item(OP_MEAS, (i % 2 == 0) ? near_echo() : miss_echo());
      end else begin
        len = $urandom_range(1, 5);
        for (i = 0; i < len; i++) send_item(1'($urandom_range(0, 1)), ECHO_W'($urandom));
      end
    end
  endtask

  task automatic test_random_scan();
    int start;
    start = items_sent;
    while (items_sent - start < RANDOM_ITEMS) run_random_phase();
    no_idle = 1'b0;
  endtask

  initial begin
    reset_scan_state();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_default_sweep_and_hold();
    test_config_extremes();
    test_counter_saturation();
    test_random_scan();
    settle_block();
    if (err_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/sshu_pkg.sv
hdl/sshu_cfg_regs.sv
hdl/sshu_detect.sv
hdl/sshu_sweep.sv
hdl/sweep_scanner_with_detect_hold_unit.sv
bench/sweep_scanner_with_detect_hold_unit_tb.sv
